[rtl/hbm_pkg.sv]
// Shared types and constants for the per-node heartbeat monitor.
// Used by hbm_node_mem and multi_node_heartbeat_monitor_core; no dependencies.
`default_nettype none

package hbm_pkg;

  localparam int NUM_NODES_DEF  = 16;
  localparam int COUNT_BITS_DEF = 4;

  // Register reset values.
  localparam logic [3:0]  RELOAD_RST = 4'd3;
  localparam logic [3:0]  WARN_RST   = 4'd1;
  localparam logic [31:0] MAGIC_RST  = 32'd0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RELOAD = 2'd0;
  localparam logic [1:0] CFG_WARN   = 2'd1;
  localparam logic [1:0] CFG_MAGIC  = 2'd2;

  typedef enum logic [1:0] {
    K_MSG    = 2'd0,
    K_TICK   = 2'd1,
    K_PAUSE  = 2'd2,
    K_RESUME = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EV_OWN   = 2'd0,
    EV_SLOW  = 2'd1,
    EV_BAD   = 2'd2,
    EV_FAULT = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSG,
    S_SCAN,
    S_WALK,
    S_OWN
  } state_t;

endpackage

`default_nettype wire

[rtl/hbm_node_mem.sv]
// Node state memory: one {seen, miss counter} word per node, read through a registered port.
// Per-entry valid bits make unwritten entries read as the reset value. Uses hbm_pkg.
`default_nettype none

module hbm_node_mem import hbm_pkg::*; #(
  parameter int NUM_NODES  = NUM_NODES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic                       rd_seen,
  output logic [COUNT_BITS-1:0]      rd_cnt,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic                  wr_seen,
  input  wire logic [COUNT_BITS-1:0] wr_cnt
);

  localparam int CNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int RST_VAL = (int'(RELOAD_RST) > CNT_MAX) ? CNT_MAX : int'(RELOAD_RST);
  localparam logic [COUNT_BITS-1:0] RST_CNT = COUNT_BITS'(RST_VAL);

  logic [COUNT_BITS:0]  mem [NUM_NODES];
  logic [NUM_NODES-1:0] valid;
  logic [COUNT_BITS:0]  q;
  logic                 q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_seen, wr_cnt};
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_seen = q_valid ? q[COUNT_BITS] : 1'b0;
  assign rd_cnt  = q_valid ? q[COUNT_BITS-1:0] : RST_CNT;

endmodule

`default_nettype wire

[rtl/multi_node_heartbeat_monitor_core.sv]
// Top level of the per-node heartbeat watchdog: request handling, tick walk and result register.
// Depends on hbm_pkg and hbm_node_mem.
`default_nettype none

// The block watches NUM_NODES nodes whose state lives in a single-port-read node memory.
// A request is taken only while the block is idle. A message request reads the memory, then
// writes it back, and yields at most one bad-heartbeat result. A tick makes a first pass over
// the node memory, one node per cycle through its read port, to find whether any node faults,
// and a second pass decrements each seen node's counter and reports warnings and faults with
// the final dead and missed flags, followed by the own heartbeat. Pause, resume, ignored
// messages and paused or dead ticks stay in the idle state. Output stalls hold a bad message,
// the walk and the own heartbeat. There is no clearing pass after reset.
module multi_node_heartbeat_monitor_core import hbm_pkg::*; #(
  parameter int NUM_NODES  = NUM_NODES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // sender[7:0], payload[39:8]
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // node[3:0], dead[4], any_missed[5], zero[7:6]
  output logic [1:0]       m_tuser,   // event_res[1:0]
  output logic             m_tlast
);

  localparam int AW      = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int IW      = $clog2(NUM_NODES + 1);
  localparam int ZW      = $clog2(NUM_NODES + 1);
  localparam int CNT_MAX = (1 << COUNT_BITS) - 1;
  localparam logic [COUNT_BITS-1:0] CNT_LIM = COUNT_BITS'(CNT_MAX);

  // Configuration registers.
  logic [3:0]  reload_count;
  logic [3:0]  warn_level;
  logic [31:0] magic_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_count <= RELOAD_RST;
      warn_level   <= WARN_RST;
      magic_word   <= MAGIC_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RELOAD: reload_count <= cfg_wdata[3:0];
        CFG_WARN:   warn_level   <= cfg_wdata[3:0];
        CFG_MAGIC:  magic_word   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state.
  state_t          state, state_next;
  logic [IW-1:0]   idx, idx_next;
  logic            fault_any, fault_next;
  logic [ZW-1:0]   nfault, nfault_next;
  logic [ZW-1:0]   zcount, zcount_next;
  logic            paused, paused_next;
  logic            dead_latch, dead_next;
  logic [AW-1:0]   msg_addr, msg_addr_next;
  logic            bad_msg, bad_next;

  // Memory port.
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  rd_seen;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic                  wr_seen;
  logic [COUNT_BITS-1:0] wr_cnt;

  // Output register.
  logic       ovalid;
  event_t     o_event;
  logic [3:0] o_node;
  logic       o_last, o_dead, o_miss;
  logic       o_load;
  event_t     ld_event;
  logic [3:0] ld_node;
  logic       ld_last, ld_dead, ld_miss;
  logic       out_free;

  hbm_node_mem #(
    .NUM_NODES  (NUM_NODES),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_seen (rd_seen),
    .rd_cnt  (rd_cnt),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_seen (wr_seen),
    .wr_cnt  (wr_cnt)
  );

  // Request decode.
  kind_t       in_kind;
  logic [7:0]  sender;
  logic [31:0] payload;
  logic [7:0]  sender_m1;
  logic        sender_ok;
  logic        accept;

  assign in_kind   = kind_t'(s_tuser);
  assign sender    = s_tdata[7:0];
  assign payload   = s_tdata[39:8];
  assign sender_m1 = sender - 8'd1;
  assign sender_ok = (sender != 8'd0) && (sender <= 8'(NUM_NODES));
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !ovalid || m_tready;

  // Per-node arithmetic on the word read from memory.
  logic [7:0]            reload_ext;
  logic [COUNT_BITS-1:0] load_val;
  logic [COUNT_BITS-1:0] dec_cnt;
  logic                  dec_zero;
  logic                  walk_emit;
  logic [ZW-1:0]         zcount_msg;
  logic                  last_idx;
  logic [IW-1:0]         idx_inc;

  assign reload_ext = 8'(reload_count);
  assign load_val   = (reload_ext > 8'(CNT_MAX)) ? CNT_LIM : reload_ext[COUNT_BITS-1:0];
  assign dec_cnt    = (rd_cnt != '0) ? rd_cnt - COUNT_BITS'(1) : '0;
  assign dec_zero   = (dec_cnt == '0);
  assign walk_emit  = rd_seen && (dec_zero || (8'(dec_cnt) == 8'(warn_level)));
  assign zcount_msg = zcount - ZW'(rd_seen && (rd_cnt == '0)) + ZW'(load_val == '0);
  assign last_idx   = (idx == IW'(NUM_NODES - 1));
  assign idx_inc    = idx + IW'(1);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    fault_next    = fault_any;
    nfault_next   = nfault;
    zcount_next   = zcount;
    paused_next   = paused;
    dead_next     = dead_latch;
    msg_addr_next = msg_addr;
    bad_next      = bad_msg;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = idx[AW-1:0];
    wr_seen       = 1'b1;
    wr_cnt        = dec_cnt;
    o_load        = 1'b0;
    ld_event      = EV_OWN;
    ld_node       = '0;
    ld_last       = 1'b0;
    ld_dead       = 1'b0;
    ld_miss       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            K_MSG: begin
              if (sender_ok) begin
                rd_en         = 1'b1;
                rd_addr       = sender_m1[AW-1:0];
                msg_addr_next = sender_m1[AW-1:0];
                bad_next      = (payload != magic_word);
                state_next    = S_MSG;
              end
            end
            K_TICK: begin
              if (!paused && !dead_latch) begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                idx_next    = '0;
                fault_next  = 1'b0;
                nfault_next = '0;
                state_next  = S_SCAN;
              end
            end
            K_PAUSE:  paused_next = 1'b1;
            K_RESUME: paused_next = 1'b0;
            default: ;
          endcase
        end
      end
      S_MSG: begin
        if (!bad_msg || out_free) begin
          wr_en       = 1'b1;
          wr_addr     = msg_addr;
          wr_cnt      = load_val;
          zcount_next = zcount_msg;
          if (bad_msg) begin
            o_load   = 1'b1;
            ld_event = EV_BAD;
            ld_node  = 4'(msg_addr);
            ld_last  = 1'b1;
            ld_dead  = dead_latch;
            ld_miss  = (zcount_msg != '0);
          end
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        // A seen node at one or zero lands on zero in this tick.
        if (rd_seen && (rd_cnt <= COUNT_BITS'(1))) begin
          fault_next  = 1'b1;
          nfault_next = nfault + ZW'(1);
        end
        rd_en = 1'b1;
        if (last_idx) begin
          rd_addr    = '0;
          idx_next   = '0;
          state_next = S_WALK;
        end else begin
          rd_addr  = idx_inc[AW-1:0];
          idx_next = idx_inc;
        end
      end
      S_WALK: begin
        if (!walk_emit || out_free) begin
          wr_en    = rd_seen;
          wr_addr  = idx[AW-1:0];
          wr_cnt   = dec_cnt;
          o_load   = walk_emit;
          ld_event = dec_zero ? EV_FAULT : EV_SLOW;
          ld_node  = 4'(idx);
          ld_dead  = fault_any;
          ld_miss  = fault_any;
          if (last_idx) begin
            state_next = S_OWN;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx_inc[AW-1:0];
            idx_next = idx_inc;
          end
        end
      end
      S_OWN: begin
        if (out_free) begin
          o_load      = 1'b1;
          ld_event    = EV_OWN;
          ld_last     = 1'b1;
          ld_dead     = fault_any;
          ld_miss     = fault_any;
          dead_next   = fault_any;
          zcount_next = nfault;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      fault_any  <= 1'b0;
      nfault     <= '0;
      zcount     <= '0;
      paused     <= 1'b0;
      dead_latch <= 1'b0;
      msg_addr   <= '0;
      bad_msg    <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      fault_any  <= fault_next;
      nfault     <= nfault_next;
      zcount     <= zcount_next;
      paused     <= paused_next;
      dead_latch <= dead_next;
      msg_addr   <= msg_addr_next;
      bad_msg    <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (o_load) begin
      ovalid <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_event <= ld_event;
      o_node  <= ld_node;
      o_last  <= ld_last;
      o_dead  <= ld_dead;
      o_miss  <= ld_miss;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {2'b00, o_miss, o_dead, o_node};
  assign m_tuser  = o_event;
  assign m_tlast  = o_last;

  // The walk writes one node while reading the next, never the same entry.
  a_mem_no_collide: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("node memory read and write hit the same entry");

  // A waiting result is never overwritten.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    o_load |-> out_free)
    else $error("result register loaded while full and stalled");

  // Only the own heartbeat and a bad-heartbeat result close a request.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == ((m_tuser == EV_OWN) || (m_tuser == EV_BAD))))
    else $error("last flag does not match result kind");

  // Ticks never run once the dead state has latched.
  a_no_walk_when_dead: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) || (state == S_WALK)) |-> !dead_latch)
    else $error("tick walk running while dead");

  a_zcount_range: assert property (@(posedge clk) disable iff (rst)
    zcount <= ZW'(NUM_NODES))
    else $error("missed-node count out of range");

endmodule

`default_nettype wire

[tb/sv/tb_multi_node_heartbeat_monitor_core.sv]
// Self-checking testbench for multi_node_heartbeat_monitor_core: heartbeat requests go in,
// and a built-in predictor of the node counters checks every event that comes out.
// Depends on hbm_pkg and the RTL of the core; it needs no files and no arguments.
`timescale 1ns / 1ps

module tb_multi_node_heartbeat_monitor_core import hbm_pkg::*; ();

  localparam int NODES = NUM_NODES_DEF;

  typedef struct packed {
    event_t     ev;
    logic [3:0] node;
    logic       last;
    logic       dead;
    logic       missed;
  } hb_event_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // sender[7:0], payload[39:8]
  logic [1:0]  s_tuser;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // node[3:0], dead[4], any_missed[5], zero[7:6]
  logic [1:0]  m_tuser;   // event_res[1:0]
  logic        m_tlast;

  // Predictor copy of the block's registers and node state.
  logic [3:0]  reload_q;
  logic [3:0]  warn_q;
  logic [31:0] magic_q;
  logic [3:0]  miss_cnt [NODES];
  logic        seen_q [NODES];
  logic        paused_q;
  logic        dead_q;

  hb_event_t   pending_events[$];
  hb_event_t   want;
  int          mismatches;
  int          src_idle_pct;
  int          snk_stall_pct;

  multi_node_heartbeat_monitor_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[multi_node_heartbeat_monitor_core] ERROR");
    $finish;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Compare each accepted event with the oldest one the predictor queued.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected event: ev=%0d node=%0d last=%0b dead=%0b missed=%0b",
                   m_tuser, m_tdata[3:0], m_tlast, m_tdata[4], m_tdata[5]);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (m_tuser !== want.ev || m_tdata[3:0] !== want.node || m_tlast !== want.last ||
            m_tdata[4] !== want.dead || m_tdata[5] !== want.missed) begin
          if (mismatches < 10)
            $display({"event mismatch: exp ev=%0d node=%0d last=%0b dead=%0b missed=%0b,",
                      " got ev=%0d node=%0d last=%0b dead=%0b missed=%0b"},
                     want.ev, want.node, want.last, want.dead, want.missed,
                     m_tuser, m_tdata[3:0], m_tlast, m_tdata[4], m_tdata[5]);
          mismatches++;
        end
      end
    end
  end

  task automatic predict_request(kind_t k, logic [7:0] sender, logic [31:0] payload);
    hb_event_t evs[$];
    hb_event_t e;
    logic      fault;
    logic      missed;
    int        idx;
    fault = 1'b0;
    missed = 1'b0;
    e = '0;
    case (k)
      K_MSG: begin
        if (sender == 8'd0 || sender > NODES) return;
        idx = sender - 1;
        seen_q[idx] = 1'b1;
        miss_cnt[idx] = reload_q;
        if (payload != magic_q) begin
          e.ev = EV_BAD;
          e.node = idx[3:0];
          evs.push_back(e);
        end
      end
      K_PAUSE: paused_q = 1'b1;
      K_RESUME: paused_q = 1'b0;
      default: begin
        if (paused_q || dead_q) return;
        for (int i = 0; i < NODES; i++) begin
          if (seen_q[i]) begin
            if (miss_cnt[i] != 4'd0) miss_cnt[i] = miss_cnt[i] - 4'd1;
            e.node = i[3:0];
            // A counter at zero is a fault even when the warning level is zero too.
            if (miss_cnt[i] == 4'd0) begin
              e.ev = EV_FAULT;
              evs.push_back(e);
              fault = 1'b1;
            end else if (miss_cnt[i] == warn_q) begin
              e.ev = EV_SLOW;
              evs.push_back(e);
            end
          end
        end
        if (fault) dead_q = 1'b1;
        e.ev = EV_OWN;
        e.node = 4'd0;
        evs.push_back(e);
      end
    endcase
    for (int i = 0; i < NODES; i++)
      if (seen_q[i] && miss_cnt[i] == 4'd0) missed = 1'b1;
    foreach (evs[j]) begin
      evs[j].last = (j == evs.size() - 1);
      evs[j].dead = dead_q;
      evs[j].missed = missed;
      pending_events.push_back(evs[j]);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the request was taken.
  task automatic send_request(kind_t k, logic [7:0] sender, logic [31:0] payload);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {payload, sender};
    do @(posedge clk); while (!s_tready);
    predict_request(k, sender, payload);
    @(negedge clk);
  endtask

  // Wait for every queued event, then let any request that produces nothing finish.
  task automatic drain_events();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_config(logic [3:0] reload, logic [3:0] warn, logic [31:0] magic);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_RELOAD;
    cfg_wdata <= {28'd0, reload};
    @(negedge clk);
    reload_q = reload;
    cfg_addr <= CFG_WARN;
    cfg_wdata <= {28'd0, warn};
    @(negedge clk);
    warn_q = warn;
    cfg_addr <= CFG_MAGIC;
    cfg_wdata <= magic;
    @(negedge clk);
    magic_q = magic;
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(3))
      0, 1: return magic_q;
      2: return magic_q ^ (32'd1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  // Reload any node that the next tick would bring down to zero.
  task automatic refresh_due_nodes();
    for (int i = 0; i < NODES; i++)
      if (!paused_q && seen_q[i] && miss_cnt[i] <= 4'd1)
        send_request(K_MSG, 8'(i + 1), pick_payload());
  endtask

  task automatic run_random_traffic(int count);
    int          r;
    logic [7:0]  sender;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        if ($urandom_range(99) < 85) sender = 8'($urandom_range(1, NODES));
        else if ($urandom_range(1) == 0) sender = 8'd0;
        else sender = 8'($urandom_range(NODES + 1, 255));
        send_request(K_MSG, sender, pick_payload());
      end else if (r < 82) begin
        refresh_due_nodes();
        send_request(K_TICK, 8'($urandom), $urandom);
      end else if (r < 89) begin
        send_request(K_PAUSE, 8'($urandom), $urandom);
      end else begin
        send_request(K_RESUME, 8'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_MSG, 8'd0, 32'd0);
    send_request(K_MSG, 8'd17, 32'hFFFF_FFFF);
    send_request(K_MSG, 8'd255, 32'hFFFF_FFFF);
    send_request(K_MSG, 8'd1, 32'd0);
    send_request(K_MSG, 8'd16, 32'hFFFF_FFFF);
    send_request(K_MSG, 8'd8, 32'd1);
    send_request(K_PAUSE, 8'hFF, 32'hFFFF_FFFF);
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_RESUME, 8'd0, 32'd0);
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_MSG, 8'd1, 32'h8000_0000);
    send_request(K_MSG, 8'd8, 32'd0);
    send_request(K_MSG, 8'd16, 32'd0);
    send_request(K_TICK, 8'd0, 32'd0);
    drain_events();
  endtask

  task automatic test_config_phases();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    set_config(4'd15, 4'd0, 32'hFFFF_FFFF);
    run_random_traffic(90);
    drain_events();
    src_idle_pct = 56;
    set_config(4'd2, 4'd1, $urandom);
    run_random_traffic(90);
    drain_events();
    src_idle_pct = 0;
    snk_stall_pct = 56;
    set_config(4'd7, 4'd15, $urandom);
    run_random_traffic(90);
    drain_events();
    src_idle_pct = 31;
    snk_stall_pct = 31;
    set_config(4'd9, 4'd6, 32'd0);
    run_random_traffic(90);
    drain_events();
  endtask

  // Several nodes fault in one tick; afterwards ticks are dead but messages still count.
  task automatic test_fault_latch();
    send_request(K_RESUME, 8'd0, 32'd0);
    drain_events();
    set_config(4'd1, 4'd0, $urandom);
    send_request(K_MSG, 8'd5, magic_q);
    send_request(K_MSG, 8'd16, 32'd0);
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_MSG, 8'd3, ~magic_q);
    send_request(K_MSG, 8'd5, magic_q);
    send_request(K_PAUSE, 8'd0, 32'd0);
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_RESUME, 8'd0, 32'd0);
    send_request(K_TICK, 8'd0, 32'd0);
    send_request(K_MSG, 8'd16, ~magic_q);
    drain_events();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = CFG_RELOAD;
    cfg_wdata = 32'd0;
    s_tvalid = 1'b0;
    s_tdata = 40'd0;
    s_tuser = K_MSG;
    m_tready = 1'b0;
    mismatches = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    reload_q = RELOAD_RST;
    warn_q = WARN_RST;
    magic_q = MAGIC_RST;
    paused_q = 1'b0;
    dead_q = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      miss_cnt[i] = RELOAD_RST;
      seen_q[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_config_phases();
    test_fault_latch();

    if (mismatches == 0) begin
      $display("[multi_node_heartbeat_monitor_core] OK");
    end else begin
      $display("[multi_node_heartbeat_monitor_core] ERROR");
    end
    $finish;
  end

endmodule
